### sv/trhs_pkg.sv
// Package with the request, result, table entry and command types of the rectangle hit selector.
`default_nettype none
package trhs_pkg;

    localparam int DEF_MAX_ELEMENTS = 64;
    localparam int DEF_NUM_CASTERS  = 4;
    localparam int IDX_W            = 6;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   entry_index;
        logic               entry_valid;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [7:0]         layer;
        logic [1:0]         caster_id;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_index;
        logic             target_changed;
        logic             deselect_valid;
        logic [IDX_W-1:0] deselect_index;
        logic             select_valid;
    } t_res;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [7:0]         layer;
    } t_rect;

    typedef struct packed {
        logic capture;   // latch the request at accept and reset the search
        logic clear_we;  // write an invalid entry at the sweep address
        logic load_we;   // write the latched load request and report it
        logic rd_en;     // read the table at the scan address
        logic finish;    // resolve the target and report the query
    } t_cmd;

endpackage
`default_nettype wire

### sv/topmost_rect_hit_select.sv
// Top level of the topmost rectangle hit selector: controller plus datapath.
`default_nettype none
// Channel   Ports              Handshake
// request   i_req (t_req)      accepted at a clock edge with i_start high and o_busy low
// result    o_res (t_res)      valid for the one cycle that o_done is high
//
// A load request passes from accept through the load state to its result; a query scans
// every table entry, one per cycle, from the single memory read port, then drains and finishes.
// After reset a clearing sweep marks every entry invalid, with o_busy high throughout.
// A new request may be accepted in the cycle its predecessor's result shows.
// The receiver cannot stall; each result appears for exactly one cycle.
module topmost_rect_hit_select #(
    parameter int MAX_ELEMENTS = trhs_pkg::DEF_MAX_ELEMENTS,
    parameter int NUM_CASTERS  = trhs_pkg::DEF_NUM_CASTERS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire trhs_pkg::t_req i_req,
    output logic                o_busy,
    output logic                o_done,
    output trhs_pkg::t_res      o_res
);
    import trhs_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = (NUM_CASTERS > 1) ? $clog2(NUM_CASTERS) : 1;

    t_cmd          cmd;
    logic [AW-1:0] addr;

    trhs_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_req.mode),
        .o_cmd   (cmd),
        .o_addr  (addr),
        .o_busy  (o_busy)
    );

    trhs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .NUM_CASTERS  (NUM_CASTERS),
        .AW           (AW),
        .CW           (CW)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .i_req   (i_req),
        .o_res   (o_res),
        .o_done  (o_done)
    );

endmodule
`default_nettype wire

### sv/trhs_ctrl.sv
// Controller of the rectangle hit selector: clearing sweep, load and scan sequencing.
`default_nettype none
module trhs_ctrl #(
    parameter int MAX_ELEMENTS = trhs_pkg::DEF_MAX_ELEMENTS,
    parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_mode,
    output trhs_pkg::t_cmd     o_cmd,
    output logic [AW-1:0]      o_addr,
    output logic               o_busy
);
    import trhs_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_addr  = '0;
                    n_state = (i_mode == MODE_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD: begin
                o_cmd.load_we = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_addr = r_addr;
    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

### sv/trhs_datapath.sv
// Datapath of the rectangle hit selector: table memory, box test, best tracking and targets.
`default_nettype none
module trhs_datapath #(
    parameter int MAX_ELEMENTS = trhs_pkg::DEF_MAX_ELEMENTS,
    parameter int NUM_CASTERS  = trhs_pkg::DEF_NUM_CASTERS,
    parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    parameter int CW           = (NUM_CASTERS > 1) ? $clog2(NUM_CASTERS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire trhs_pkg::t_cmd i_cmd,
    input  wire logic [AW-1:0]  i_addr,
    input  wire trhs_pkg::t_req i_req,
    output trhs_pkg::t_res      o_res,
    output logic                o_done
);
    import trhs_pkg::*;

    t_rect         mem [MAX_ELEMENTS];
    t_req          r_req;
    t_rect         r_rd_data;
    logic [AW-1:0] r_rd_idx;
    logic          r_rd_valid;

    logic          r_found;
    logic [7:0]    r_best_layer;
    logic [AW-1:0] r_best_idx;
    logic          r_tgt_live;

    logic          r_tgt_valid [NUM_CASTERS];
    logic [AW-1:0] r_tgt_idx   [NUM_CASTERS];

    t_res          r_res;
    logic          r_done;

    // Table write port: clearing sweep or a latched load request.
    logic          load_in_range;
    logic          we;
    logic [AW-1:0] waddr;
    t_rect         wdata;

    assign load_in_range = (32'(r_req.entry_index) < MAX_ELEMENTS);
    assign we    = i_cmd.clear_we || (i_cmd.load_we && load_in_range);
    assign waddr = i_cmd.clear_we ? i_addr : AW'(r_req.entry_index);

    always_comb begin
        wdata = '0;
        if (!i_cmd.clear_we) begin
            wdata.valid = r_req.entry_valid;
            wdata.cx    = r_req.center_x;
            wdata.cy    = r_req.center_y;
            wdata.w     = r_req.width;
            wdata.h     = r_req.height;
            wdata.layer = r_req.layer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_rd_idx <= i_addr;
    end

    // Box test on the entry read in the previous cycle; half sizes are truncated.
    logic signed [16:0] x_lo, x_hi, y_lo, y_hi, px, py;
    logic               in_box, better;
    logic [CW-1:0]      cidx;

    assign cidx = CW'(r_req.caster_id);
    assign px   = $signed({r_req.point_x[15], r_req.point_x});
    assign py   = $signed({r_req.point_y[15], r_req.point_y});
    assign x_lo = $signed({r_rd_data.cx[15], r_rd_data.cx}) - $signed({3'b000, r_rd_data.w[14:1]});
    assign x_hi = $signed({r_rd_data.cx[15], r_rd_data.cx}) + $signed({3'b000, r_rd_data.w[14:1]});
    assign y_lo = $signed({r_rd_data.cy[15], r_rd_data.cy}) - $signed({3'b000, r_rd_data.h[14:1]});
    assign y_hi = $signed({r_rd_data.cy[15], r_rd_data.cy}) + $signed({3'b000, r_rd_data.h[14:1]});
    assign in_box = (px >= x_lo) && (px <= x_hi) && (py >= y_lo) && (py <= y_hi);
    // Strictly greater keeps the lowest index on equal layers.
    assign better = r_rd_valid && r_rd_data.valid && in_box &&
                    (!r_found || (r_rd_data.layer > r_best_layer));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_found      <= 1'b0;
            r_best_layer <= '0;
            r_best_idx   <= '0;
            r_tgt_live   <= 1'b0;
        end else begin
            if (better) begin
                r_found      <= 1'b1;
                r_best_layer <= r_rd_data.layer;
                r_best_idx   <= r_rd_idx;
            end
            // The scan passes the old target's slot once; note whether it is still present.
            if (r_rd_valid && (r_rd_idx == r_tgt_idx[cidx])) begin
                r_tgt_live <= r_rd_data.valid;
            end
        end
    end

    // Target resolution at the end of a query.
    logic cid_ok, t_valid, same, changed, desel;
    logic [AW-1:0] t_idx;
    t_res q_res;

    assign cid_ok  = (32'(r_req.caster_id) < NUM_CASTERS);
    assign t_valid = r_tgt_valid[cidx];
    assign t_idx   = r_tgt_idx[cidx];
    assign same    = (t_valid == r_found) && (!r_found || (t_idx == r_best_idx));
    assign changed = cid_ok && !same;
    assign desel   = changed && t_valid && r_tgt_live;

    always_comb begin
        q_res                = '0;
        q_res.hit            = r_found;
        q_res.hit_index      = IDX_W'(r_best_idx);
        q_res.target_changed = changed;
        q_res.deselect_valid = desel;
        q_res.deselect_index = desel ? IDX_W'(t_idx) : '0;
        q_res.select_valid   = changed && r_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CASTERS; c++) begin
                r_tgt_valid[c] <= 1'b0;
                r_tgt_idx[c]   <= '0;
            end
        end else if (i_cmd.finish && changed) begin
            r_tgt_valid[cidx] <= r_found;
            r_tgt_idx[cidx]   <= r_found ? r_best_idx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.load_we || i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_res <= '0;
        end else if (i_cmd.finish) begin
            r_res <= q_res;
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule
`default_nettype wire
